// ===== rtl/stp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int PERIOD_BITS_DEF   = 24;

    localparam int STEP_PERIOD_RESET = 1500;
    localparam int REV_STEPS_RESET   = 16000;

    localparam int ACTION_BITS    = 3;
    localparam int CFG_INDEX_BITS = 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_PERIOD = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REV_STEPS   = 1'b1;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_TICK       = 3'd0,
        ACT_ROTATE     = 3'd1,
        ACT_CONTINUOUS = 3'd2,
        ACT_STOP_CONT  = 3'd3,
        ACT_RASTER     = 3'd4,
        ACT_HOME       = 3'd5,
        ACT_SINGLE     = 3'd6,
        ACT_SET_DIR    = 3'd7
    } t_action;

    typedef struct packed {
        logic rotate;
        logic continuous;
        logic raster;
        logic home;
    } t_modes;

endpackage

`default_nettype wire

// ===== rtl/stp_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stp_cfg_regs #(
    parameter int POSITION_BITS = stp_pkg::POSITION_BITS_DEF,
    parameter int PERIOD_BITS   = stp_pkg::PERIOD_BITS_DEF,
    parameter int CFG_BITS      = (PERIOD_BITS > POSITION_BITS) ? PERIOD_BITS : POSITION_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [stp_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_BITS-1:0]                 i_cfg_wdata,
    output logic      [PERIOD_BITS-1:0]              o_step_period,
    output logic      [POSITION_BITS-1:0]            o_rev_steps
);

    logic [PERIOD_BITS-1:0]   r_step_period;
    logic [POSITION_BITS-1:0] r_rev_steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_period <= PERIOD_BITS'(stp_pkg::STEP_PERIOD_RESET);
            r_rev_steps   <= POSITION_BITS'(stp_pkg::REV_STEPS_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                stp_pkg::CFG_STEP_PERIOD: begin
                    r_step_period <= i_cfg_wdata[PERIOD_BITS-1:0];
                end
                stp_pkg::CFG_REV_STEPS: begin
                    r_rev_steps <= i_cfg_wdata[POSITION_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_step_period = r_step_period;
    assign o_rev_steps   = r_rev_steps;

endmodule

`default_nettype wire

// ===== rtl/stp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stp_core #(
    parameter int POSITION_BITS = stp_pkg::POSITION_BITS_DEF,
    parameter int PERIOD_BITS   = stp_pkg::PERIOD_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_advance,
    input  wire stp_pkg::t_action          i_action,
    input  wire logic [POSITION_BITS-1:0]  i_target,
    input  wire logic [POSITION_BITS-1:0]  i_span,
    input  wire logic                      i_dir_value,
    input  wire logic                      i_home_sensor,
    input  wire logic [PERIOD_BITS-1:0]    i_step_period,
    input  wire logic [POSITION_BITS-1:0]  i_rev_steps,
    output logic                           o_pulse,
    output logic                           o_dir,
    output logic      [POSITION_BITS-1:0]  o_pos,
    output stp_pkg::t_modes                o_modes
);

    localparam int OFF_BITS = POSITION_BITS + 1;

    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [PERIOD_BITS-1:0]   r_elapsed, n_elapsed;
    logic                     r_dir, n_dir;
    stp_pkg::t_modes          r_modes, n_modes;
    logic [OFF_BITS-1:0]      r_home_steps, n_home_steps;
    logic [OFF_BITS-1:0]      r_offset, n_offset;
    logic [POSITION_BITS-1:0] r_target, n_target;
    logic [POSITION_BITS-1:0] r_span, n_span;
    logic                     n_pulse;

    logic [PERIOD_BITS-1:0]   w_elapsed_inc;
    logic                     w_due;
    logic [POSITION_BITS-1:0] w_pos_inc;
    logic [POSITION_BITS-1:0] w_fwd;
    logic [POSITION_BITS-1:0] w_bwd;
    logic [POSITION_BITS-1:0] w_raster_pos;
    logic [OFF_BITS-1:0]      w_off_next;
    logic [OFF_BITS:0]        w_off_ext;
    logic [OFF_BITS:0]        w_off_neg;
    logic [OFF_BITS:0]        w_half;
    logic                     w_raster_dir;
    logic                     w_home_done;

    // timer saturates at full scale
    assign w_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    assign w_due         = (w_elapsed_inc >= i_step_period);

    assign w_pos_inc = r_pos + 1'b1;
    assign w_fwd     = (w_pos_inc >= i_rev_steps) ? '0 : w_pos_inc;
    assign w_bwd     = (r_pos == '0 || r_pos > i_rev_steps)
                     ? ((i_rev_steps == '0) ? '0 : i_rev_steps - 1'b1)
                     : r_pos - 1'b1;

    // raster: move, then reverse once the signed offset reaches half the span
    assign w_raster_pos = r_dir ? w_bwd : w_fwd;
    assign w_off_next   = r_dir ? r_offset - 1'b1 : r_offset + 1'b1;
    assign w_off_ext    = {w_off_next[OFF_BITS-1], w_off_next};
    assign w_off_neg    = '0 - w_off_ext;
    assign w_half       = {3'b000, r_span[POSITION_BITS-1:1]};
    assign w_raster_dir = ($signed(w_off_ext) >= $signed(w_half)) ? 1'b1
                        : ($signed(w_off_neg) >= $signed(w_half)) ? 1'b0
                        : r_dir;

    assign w_home_done = i_home_sensor || (r_home_steps > {1'b0, i_rev_steps});

    always_comb begin
        n_pos        = r_pos;
        n_elapsed    = r_elapsed;
        n_dir        = r_dir;
        n_modes      = r_modes;
        n_home_steps = r_home_steps;
        n_offset     = r_offset;
        n_target     = r_target;
        n_span       = r_span;
        n_pulse      = 1'b0;
        unique case (i_action)
            stp_pkg::ACT_TICK: begin
                n_elapsed = w_elapsed_inc;
                if (w_due) begin
                    priority if (r_modes.home) begin
                        if (w_home_done) begin
                            n_modes.home = 1'b0;
                            n_home_steps = '0;
                            n_pos        = '0;
                        end else begin
                            n_pulse      = 1'b1;
                            n_pos        = w_fwd;
                            n_elapsed    = '0;
                            if (r_home_steps != '1) begin
                                n_home_steps = r_home_steps + 1'b1;
                            end
                        end
                    end else if (r_modes.raster) begin
                        n_pulse   = 1'b1;
                        n_pos     = w_raster_pos;
                        n_offset  = w_off_next;
                        n_elapsed = '0;
                        n_dir     = w_raster_dir;
                    end else if (r_modes.rotate) begin
                        n_pulse   = 1'b1;
                        n_pos     = w_fwd;
                        n_elapsed = '0;
                        if (w_fwd == r_target) begin
                            n_modes.rotate = 1'b0;
                        end
                    end else if (r_modes.continuous) begin
                        n_pulse   = 1'b1;
                        n_pos     = w_fwd;
                        n_elapsed = '0;
                    end else begin
                    end
                end
            end
            stp_pkg::ACT_ROTATE: begin
                n_target       = i_target;
                n_modes.rotate = 1'b1;
                n_elapsed      = '0;
            end
            stp_pkg::ACT_CONTINUOUS: begin
                n_modes.continuous = 1'b1;
                n_elapsed          = '0;
            end
            stp_pkg::ACT_STOP_CONT: begin
                n_modes.continuous = 1'b0;
            end
            stp_pkg::ACT_RASTER: begin
                n_span         = i_span;
                n_offset       = '0;
                n_modes.raster = 1'b1;
                n_elapsed      = '0;
            end
            stp_pkg::ACT_HOME: begin
                n_modes.home = 1'b1;
                n_elapsed    = '0;
            end
            stp_pkg::ACT_SINGLE: begin
                if (!r_modes.raster) begin
                    n_pulse = 1'b1;
                    n_pos   = w_fwd;
                end
            end
            stp_pkg::ACT_SET_DIR: begin
                n_dir = i_dir_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_elapsed    <= '0;
            r_dir        <= 1'b0;
            r_modes      <= '0;
            r_home_steps <= '0;
            r_offset     <= '0;
            r_target     <= '0;
            r_span       <= '0;
        end else if (i_advance) begin
            r_pos        <= n_pos;
            r_elapsed    <= n_elapsed;
            r_dir        <= n_dir;
            r_modes      <= n_modes;
            r_home_steps <= n_home_steps;
            r_offset     <= n_offset;
            r_target     <= n_target;
            r_span       <= n_span;
        end
    end

    assign o_pulse = n_pulse;
    assign o_dir   = n_dir;
    assign o_pos   = n_pos;
    assign o_modes = n_modes;

endmodule

`default_nettype wire

// ===== rtl/stepper_step_sequencer.sv =====
// Stepper step-pulse sequencer.
// Input stream (i_s_*): one request per microsecond tick or command. tuser carries
// the action code; tdata carries target, raster span, direction value and the home
// sensor level. Output stream (o_m_*): one result per request with the step pulse,
// direction pin, position and the four mode flags.
// Configuration: i_cfg_we writes step_period (index 0) or the revolution length
// (index 1) at the clock edge; write only while no request is in flight.
// A request waits in the input register until the output side is free; then its
// result is registered. Throughput: one request per cycle while results are taken;
// the step state is read and rewritten as a request moves to the result register.
// Reset (i_rst_n low, synchronous): clears position, timer, direction and modes,
// loads step_period 1500 and a revolution of 16000 steps, and empties both stages.
// Stall: with i_m_tready low the result holds; the block takes one more request
// into its input register and then drops o_s_tready until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module stepper_step_sequencer #(
    parameter int POSITION_BITS = stp_pkg::POSITION_BITS_DEF,
    parameter int PERIOD_BITS   = stp_pkg::PERIOD_BITS_DEF,
    parameter int CFG_BITS      = (PERIOD_BITS > POSITION_BITS) ? PERIOD_BITS : POSITION_BITS,
    parameter int IN_W          = ((2 * POSITION_BITS + 2 + 7) / 8) * 8,
    parameter int OUT_W         = ((POSITION_BITS + 6 + 7) / 8) * 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // target_steps, raster_span_steps, direction_value, home_sensor, zero pad
    input  wire logic [IN_W-1:0]                     i_s_tdata,
    // action
    input  wire logic [stp_pkg::ACTION_BITS-1:0]     i_s_tuser,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // step_pulse, direction_out, position, rotating, continuous, rastering,
    // homing, zero pad
    output logic      [OUT_W-1:0]                    o_m_tdata,
    input  wire logic                                i_cfg_we,
    input  wire logic [stp_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_BITS-1:0]                 i_cfg_wdata
);

    localparam int P = POSITION_BITS;

    logic                             r_in_valid;
    logic [stp_pkg::ACTION_BITS-1:0]  r_in_action;
    logic [P-1:0]                     r_in_target;
    logic [P-1:0]                     r_in_span;
    logic                             r_in_dir;
    logic                             r_in_home;
    logic                             r_out_valid;
    logic [OUT_W-1:0]                 r_out_data;
    logic [OUT_W-1:0]                 n_out_data;

    logic                             w_advance;
    logic                             w_accept;
    logic [PERIOD_BITS-1:0]           w_step_period;
    logic [P-1:0]                     w_rev_steps;
    logic                             w_pulse;
    logic                             w_dir;
    logic [P-1:0]                     w_pos;
    stp_pkg::t_modes                  w_modes;

    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_accept   = i_s_tvalid && o_s_tready;

    stp_cfg_regs #(
        .POSITION_BITS (POSITION_BITS),
        .PERIOD_BITS   (PERIOD_BITS),
        .CFG_BITS      (CFG_BITS)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_step_period (w_step_period),
        .o_rev_steps   (w_rev_steps)
    );

    stp_core #(
        .POSITION_BITS (POSITION_BITS),
        .PERIOD_BITS   (PERIOD_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (w_advance),
        .i_action      (stp_pkg::t_action'(r_in_action)),
        .i_target      (r_in_target),
        .i_span        (r_in_span),
        .i_dir_value   (r_in_dir),
        .i_home_sensor (r_in_home),
        .i_step_period (w_step_period),
        .i_rev_steps   (w_rev_steps),
        .o_pulse       (w_pulse),
        .o_dir         (w_dir),
        .o_pos         (w_pos),
        .o_modes       (w_modes)
    );

    always_comb begin
        n_out_data          = '0;
        n_out_data[0]       = w_pulse;
        n_out_data[1]       = w_dir;
        n_out_data[P+1:2]   = w_pos;
        n_out_data[P+2]     = w_modes.rotate;
        n_out_data[P+3]     = w_modes.continuous;
        n_out_data[P+4]     = w_modes.raster;
        n_out_data[P+5]     = w_modes.home;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_action <= i_s_tuser;
            r_in_target <= i_s_tdata[P-1:0];
            r_in_span   <= i_s_tdata[2*P-1:P];
            r_in_dir    <= i_s_tdata[2*P];
            r_in_home   <= i_s_tdata[2*P+1];
        end
        if (w_advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/stp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stp_checker #(
    parameter int IN_W  = 40,
    parameter int OUT_W = 24
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_s_tvalid,
    input wire logic               o_s_tready,
    input wire logic               o_m_tvalid,
    input wire logic               i_m_tready,
    input wire logic [OUT_W-1:0]   o_m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // an empty result stage never blocks a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty result stage");

    // accepted request, with the receiver ready after it, shows up as a valid result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) ##1 i_m_tready |=> o_m_tvalid)
        else $error("accepted request produced no result");

endmodule

bind stepper_step_sequencer stp_checker #(
    .IN_W  (IN_W),
    .OUT_W (OUT_W)
) u_stp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
